// ----- rtl/core/frp_pkg.sv -----
package frp_pkg;

    localparam int TIME_W   = 63;
    localparam int HANDLE_W = 16;
    localparam int SLOT_W   = 32;
    localparam int RATE_W   = 10;
    localparam int LIMIT_W  = 6;
    localparam int PERIOD_W = 30;
    localparam int WIDE_W   = 64;
    localparam int CFG_W    = 10;
    localparam int CFG_IDX_W = 1;

    localparam logic [PERIOD_W-1:0] NS_PER_SECOND = PERIOD_W'(1000000000);
    localparam logic [RATE_W-1:0]   RATE_RESET    = RATE_W'(30);
    localparam logic [PERIOD_W-1:0] PERIOD_RESET  = PERIOD_W'(1000000000 / 30);
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET   = LIMIT_W'(2);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OUTPUT_RATE     = 1'b0,
        REG_SKIP_WARN_LIMIT = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        RC_IDLE,
        RC_DIV,
        RC_ROUND,
        RC_GAP,
        RC_DECIDE,
        RC_EMIT
    } run_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- rtl/core/frp_in_if.sv -----
interface frp_in_if;
    logic                          valid;
    logic                          ready;
    logic [frp_pkg::TIME_W-1:0]    capture_time_ns;
    logic [frp_pkg::HANDLE_W-1:0]  frame_handle;

    modport source (output valid, output capture_time_ns, output frame_handle, input ready);
    modport sink   (input valid, input capture_time_ns, input frame_handle, output ready);
endinterface

// ----- rtl/core/frp_out_if.sv -----
interface frp_out_if;
    logic                          valid;
    logic                          ready;
    logic [frp_pkg::HANDLE_W-1:0]  out_handle;
    logic [frp_pkg::SLOT_W-1:0]    slot_number;
    logic                          is_repeat;
    logic                          skip_warning;
    logic                          order_error;
    logic                          last_of_run;

    modport source (output valid, output out_handle, output slot_number, output is_repeat,
                    output skip_warning, output order_error, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_handle, input slot_number, input is_repeat,
                    input skip_warning, input order_error, input last_of_run,
                    output ready);
endinterface

// ----- rtl/core/frp_serial_div.sv -----
module frp_serial_div #(
    parameter int DIVIDEND_W = 63,
    parameter int DIVISOR_W  = 30
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [DIVIDEND_W-1:0]  dividend,
    input  logic [DIVISOR_W-1:0]   divisor,
    output frp_pkg::div_stat_t     status,
    output logic [DIVIDEND_W-1:0]  quotient,
    output logic [DIVISOR_W-1:0]   remainder
);

    localparam int CW = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] acc_reg, acc_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    assign trial = {rem_reg, acc_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = ~diff[DIVISOR_W];

    always_comb
    begin
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CW'(DIVIDEND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = {acc_reg[DIVIDEND_W-2:0], fits};
            rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = acc_reg;
    assign remainder   = rem_reg;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("division finished without running");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < dvs_reg))
        else $error("remainder not below divisor");
`endif

endmodule

// ----- rtl/core/frp_run_ctrl.sv -----
module frp_run_ctrl #(
    parameter int MAX_REPEATS = 63
) (
    input  logic                            clk,
    input  logic                            rst_n,
    frp_in_if.sink                          frame_in,
    frp_out_if.source                       result_out,
    input  logic                            period_busy,
    input  logic [frp_pkg::PERIOD_W-1:0]    period,
    input  logic [frp_pkg::LIMIT_W-1:0]     warn_limit,
    output logic                            div_start,
    input  frp_pkg::div_stat_t              div_status,
    input  logic [frp_pkg::TIME_W-1:0]      div_quotient,
    input  logic [frp_pkg::PERIOD_W-1:0]    div_remainder
);

    localparam int RW = $clog2(MAX_REPEATS + 1);
    localparam int W  = frp_pkg::WIDE_W;

    frp_pkg::run_state_t state_reg, state_next;

    logic [frp_pkg::HANDLE_W-1:0] handle_reg, handle_next;
    logic [W-1:0]                 slot_reg, slot_next;
    logic [W:0]                   gap_reg, gap_next;
    logic [frp_pkg::SLOT_W-1:0]   next_slot_reg, next_slot_next;
    logic [frp_pkg::SLOT_W-1:0]   cur_slot_reg, cur_slot_next;
    logic [RW-1:0]                rep_cnt_reg, rep_cnt_next;
    logic                         halted_reg, halted_next;
    logic                         warn_reg, warn_next;
    logic                         err_reg, err_next;

    logic                         out_valid_reg, out_valid_next;
    logic [frp_pkg::HANDLE_W-1:0] o_handle_reg, o_handle_next;
    logic [frp_pkg::SLOT_W-1:0]   o_slot_reg, o_slot_next;
    logic                         o_rep_reg, o_rep_next;
    logic                         o_warn_reg, o_warn_next;
    logic                         o_err_reg, o_err_next;
    logic                         o_last_reg, o_last_next;

    logic                         in_fire;
    logic                         out_load;
    logic                         round_up;

    assign frame_in.ready = (state_reg == frp_pkg::RC_IDLE) && !period_busy;
    assign in_fire   = frame_in.valid && frame_in.ready;
    assign div_start = in_fire && !halted_reg;
    assign out_load  = (state_reg == frp_pkg::RC_EMIT) && (!out_valid_reg || result_out.ready);
    assign round_up  = {div_remainder, 1'b0} > {1'b0, period};

    always_comb
    begin
        state_next     = state_reg;
        handle_next    = handle_reg;
        slot_next      = slot_reg;
        gap_next       = gap_reg;
        next_slot_next = next_slot_reg;
        cur_slot_next  = cur_slot_reg;
        rep_cnt_next   = rep_cnt_reg;
        halted_next    = halted_reg;
        warn_next      = warn_reg;
        err_next       = err_reg;
        o_handle_next  = o_handle_reg;
        o_slot_next    = o_slot_reg;
        o_rep_next     = o_rep_reg;
        o_warn_next    = o_warn_reg;
        o_err_next     = o_err_reg;
        o_last_next    = o_last_reg;
        out_valid_next = result_out.ready ? 1'b0 : out_valid_reg;

        case (state_reg)
            frp_pkg::RC_IDLE:
            begin
                if (div_start)
                begin
                    handle_next = frame_in.frame_handle;
                    state_next  = frp_pkg::RC_DIV;
                end
            end
            frp_pkg::RC_DIV:
            begin
                if (div_status.done)
                begin
                    slot_next  = {1'b0, div_quotient} + W'(round_up);
                    state_next = frp_pkg::RC_ROUND;
                end
            end
            frp_pkg::RC_ROUND:
            begin
                gap_next   = {1'b0, slot_reg} - (W + 1)'(next_slot_reg);
                state_next = frp_pkg::RC_GAP;
            end
            frp_pkg::RC_GAP:
            begin
                state_next = frp_pkg::RC_DECIDE;
            end
            frp_pkg::RC_DECIDE:
            begin
                if (!gap_reg[W])
                begin
                    warn_next     = gap_reg[W-1:0] > W'(warn_limit);
                    rep_cnt_next  = (gap_reg[W-1:0] > W'(MAX_REPEATS)) ? RW'(MAX_REPEATS)
                                                                      : gap_reg[RW-1:0];
                    cur_slot_next = next_slot_reg;
                    err_next      = 1'b0;
                    state_next    = frp_pkg::RC_EMIT;
                end
                else if (&gap_reg)
                begin
                    state_next = frp_pkg::RC_IDLE;
                end
                else
                begin
                    warn_next    = 1'b0;
                    rep_cnt_next = '0;
                    err_next     = 1'b1;
                    state_next   = frp_pkg::RC_EMIT;
                end
            end
            frp_pkg::RC_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    o_handle_next  = handle_reg;
                    o_warn_next    = warn_reg;
                    o_err_next     = err_reg;
                    if (rep_cnt_reg != '0)
                    begin
                        o_slot_next   = cur_slot_reg;
                        o_rep_next    = 1'b1;
                        o_last_next   = 1'b0;
                        rep_cnt_next  = rep_cnt_reg - RW'(1);
                        cur_slot_next = cur_slot_reg + frp_pkg::SLOT_W'(1);
                    end
                    else
                    begin
                        o_slot_next = slot_reg[frp_pkg::SLOT_W-1:0];
                        o_rep_next  = 1'b0;
                        o_last_next = 1'b1;
                        if (err_reg)
                            halted_next = 1'b1;
                        else
                            next_slot_next = slot_reg[frp_pkg::SLOT_W-1:0]
                                             + frp_pkg::SLOT_W'(1);
                        state_next = frp_pkg::RC_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = frp_pkg::RC_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= frp_pkg::RC_IDLE;
            next_slot_reg <= '0;
            halted_reg    <= 1'b0;
            rep_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_slot_reg <= next_slot_next;
            halted_reg    <= halted_next;
            rep_cnt_reg   <= rep_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        handle_reg   <= handle_next;
        slot_reg     <= slot_next;
        gap_reg      <= gap_next;
        cur_slot_reg <= cur_slot_next;
        warn_reg     <= warn_next;
        err_reg      <= err_next;
        o_handle_reg <= o_handle_next;
        o_slot_reg   <= o_slot_next;
        o_rep_reg    <= o_rep_next;
        o_warn_reg   <= o_warn_next;
        o_err_reg    <= o_err_next;
        o_last_reg   <= o_last_next;
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.out_handle   = o_handle_reg;
    assign result_out.slot_number  = o_slot_reg;
    assign result_out.is_repeat    = o_rep_reg;
    assign result_out.skip_warning = o_warn_reg;
    assign result_out.order_error  = o_err_reg;
    assign result_out.last_of_run  = o_last_reg;

`ifndef SYNTHESIS
    a_halt_blocks_results: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> !out_load)
        else $error("transaction issued after halt");

    a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && err_reg && (rep_cnt_reg == '0)) |=> halted_reg)
        else $error("order error did not halt");

    a_repeat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rep_cnt_reg <= RW'(MAX_REPEATS))
        else $error("repeat count above limit");
`endif

endmodule

// ----- rtl/core/frame_rate_pacer_top.sv -----
// Channel     | Direction | Transaction
// ------------+-----------+------------------------------------------------------
// frame_in    | sink      | capture_time_ns, frame_handle
// result_out  | source    | out_handle, slot_number, is_repeat, skip_warning,
//             |           | order_error, last_of_run
// cfg_*       | sink      | cfg_we, cfg_index, cfg_data (write only)
//
// A paced frame goes from acceptance to its first result through a 63-step serial slot
// division, then capture, round, gap, decide and load steps; each further result of
// its run is loaded as result_out accepts the one before.
// A write of output_rate starts a 30-step serial period division; frame_in is
// held off while it runs and while its quotient is stored.
// Reset clears next slot, halt flag and registers to their defaults.
// A stalled result_out holds the run; frame_in waits until the run ends.
module frame_rate_pacer_top #(
    parameter int MAX_REPEATS = 63
) (
    input  logic                              clk,
    input  logic                              rst_n,
    frp_in_if.sink                            frame_in,
    frp_out_if.source                         result_out,
    input  logic                              cfg_we,
    input  logic [frp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [frp_pkg::CFG_W-1:0]         cfg_data
);

    logic [frp_pkg::PERIOD_W-1:0] period_reg, period_next;
    logic [frp_pkg::LIMIT_W-1:0]  limit_reg, limit_next;
    logic                         rate_start;
    logic [frp_pkg::RATE_W-1:0]   rate_divisor;
    frp_pkg::div_stat_t           period_status;
    logic [frp_pkg::PERIOD_W-1:0] period_quot;
    logic                         period_busy;

    logic                         slot_start;
    frp_pkg::div_stat_t           slot_status;
    logic [frp_pkg::TIME_W-1:0]   slot_quot;
    logic [frp_pkg::PERIOD_W-1:0] slot_rem;

    assign rate_start   = cfg_we && (cfg_index == frp_pkg::REG_OUTPUT_RATE);
    assign rate_divisor = (cfg_data[frp_pkg::RATE_W-1:0] == '0) ? frp_pkg::RATE_W'(1)
                                                                : cfg_data[frp_pkg::RATE_W-1:0];
    assign period_busy  = period_status.busy || period_status.done;

    always_comb
    begin
        period_next = period_reg;
        limit_next  = limit_reg;
        if (period_status.done)
            period_next = period_quot;
        if (cfg_we && (cfg_index == frp_pkg::REG_SKIP_WARN_LIMIT))
            limit_next = cfg_data[frp_pkg::LIMIT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= frp_pkg::PERIOD_RESET;
            limit_reg  <= frp_pkg::LIMIT_RESET;
        end
        else
        begin
            period_reg <= period_next;
            limit_reg  <= limit_next;
        end
    end

    frp_serial_div #(
        .DIVIDEND_W (frp_pkg::PERIOD_W),
        .DIVISOR_W  (frp_pkg::RATE_W)
    ) u_period_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rate_start),
        .dividend  (frp_pkg::NS_PER_SECOND),
        .divisor   (rate_divisor),
        .status    (period_status),
        .quotient  (period_quot),
        .remainder ()
    );

    frp_serial_div #(
        .DIVIDEND_W (frp_pkg::TIME_W),
        .DIVISOR_W  (frp_pkg::PERIOD_W)
    ) u_slot_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (slot_start),
        .dividend  (frame_in.capture_time_ns),
        .divisor   (period_reg),
        .status    (slot_status),
        .quotient  (slot_quot),
        .remainder (slot_rem)
    );

    frp_run_ctrl #(
        .MAX_REPEATS (MAX_REPEATS)
    ) u_run_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame_in      (frame_in),
        .result_out    (result_out),
        .period_busy   (period_busy),
        .period        (period_reg),
        .warn_limit    (limit_reg),
        .div_start     (slot_start),
        .div_status    (slot_status),
        .div_quotient  (slot_quot),
        .div_remainder (slot_rem)
    );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    localparam int PACER_MAX_REPEATS = 63;

    typedef struct packed {
        logic [frp_pkg::TIME_W-1:0]   capture;
        logic [frp_pkg::HANDLE_W-1:0] handle;
    } frame_t;

    typedef struct packed {
        logic [frp_pkg::HANDLE_W-1:0] handle;
        logic [frp_pkg::SLOT_W-1:0]   slot;
        logic                         repeat_fill;
        logic                         warn;
        logic                         order_err;
        logic                         last;
    } presented_slot_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [frp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [frp_pkg::CFG_W-1:0] cfg_data;

    frp_in_if frame_in ();
    frp_out_if result_out ();

    frame_rate_pacer_top #(
        .MAX_REPEATS(PACER_MAX_REPEATS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .frame_in(frame_in),
        .result_out(result_out),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    frame_t frames_pending[$];
    presented_slot_t slots_awaited[$];
    frame_t next_frame;
    presented_slot_t seen_slot;
    presented_slot_t want_slot;

    logic [frp_pkg::RATE_W-1:0] rate_reg = frp_pkg::RATE_RESET;
    logic [frp_pkg::LIMIT_W-1:0] warn_limit_reg = frp_pkg::LIMIT_RESET;
    logic [frp_pkg::SLOT_W-1:0] pace_next_slot = '0;
    logic pace_halted = 1'b0;
    logic [frp_pkg::SLOT_W-1:0] plan_next = '0;

    int unsigned send_idle_pct = 16;
    int unsigned recv_idle_pct = 74;
    int unsigned mismatches = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] slot_period_ns();
        return 64'(frp_pkg::NS_PER_SECOND) / ((rate_reg == '0) ? 64'd1 : 64'(rate_reg));
    endfunction

    function automatic logic [63:0] slot_of(logic [frp_pkg::TIME_W-1:0] t);
        logic [63:0] per;
        logic [63:0] s;
        logic [63:0] rem;
        per = slot_period_ns();
        s = 64'(t) / per;
        rem = 64'(t) % per;
        if (rem * 2 > per)
            s = s + 1;
        return s;
    endfunction

    function automatic presented_slot_t make_slot(logic [frp_pkg::HANDLE_W-1:0] h,
                                                  logic [63:0] s,
                                                  logic rep, logic warn, logic err, logic last);
        presented_slot_t r;
        r.handle = h;
        r.slot = s[frp_pkg::SLOT_W-1:0];
        r.repeat_fill = rep;
        r.warn = warn;
        r.order_err = err;
        r.last = last;
        return r;
    endfunction

    function automatic void pace_frame(logic [frp_pkg::TIME_W-1:0] t,
                                       logic [frp_pkg::HANDLE_W-1:0] h);
        logic [63:0] s;
        logic [63:0] nxt;
        logic [63:0] gap;
        logic [63:0] reps;
        logic warn;
        if (pace_halted)
            return;
        s = slot_of(t);
        nxt = 64'(pace_next_slot);
        if (s >= nxt)
        begin
            gap = s - nxt;
            warn = gap > 64'(warn_limit_reg);
            reps = (gap > PACER_MAX_REPEATS) ? 64'(PACER_MAX_REPEATS) : gap;
            for (logic [63:0] i = 0; i < reps; i++)
                slots_awaited.push_back(make_slot(h, nxt + i, 1'b1, warn, 1'b0, 1'b0));
            slots_awaited.push_back(make_slot(h, s, 1'b0, warn, 1'b0, 1'b1));
            pace_next_slot = s[frp_pkg::SLOT_W-1:0] + 1'b1;
        end
        else if (s + 1 != nxt)
        begin
            slots_awaited.push_back(make_slot(h, s, 1'b0, 1'b0, 1'b1, 1'b1));
            pace_halted = 1'b1;
        end
    endfunction

    function automatic void push_frame(logic [frp_pkg::TIME_W-1:0] t,
                                       logic [frp_pkg::HANDLE_W-1:0] h);
        frame_t f;
        logic [63:0] s;
        f.capture = t;
        f.handle = h;
        frames_pending.push_back(f);
        s = slot_of(t);
        if (s >= 64'(plan_next))
            plan_next = s[frp_pkg::SLOT_W-1:0] + 1'b1;
    endfunction

    function automatic void frame_at(logic [63:0] target, logic [frp_pkg::HANDLE_W-1:0] h);
        push_frame(frp_pkg::TIME_W'(target * slot_period_ns()), h);
    endfunction

    function automatic void random_frame();
        logic [63:0] per;
        logic [63:0] target;
        logic [63:0] t;
        int unsigned kind;
        per = slot_period_ns();
        kind = $urandom_range(99);
        target = 64'(plan_next);
        if (kind < 12)
        begin
            t = {$urandom(), $urandom()} & 64'h7FFF_FFFF_FFFF_FFFF;
            if (slot_of(frp_pkg::TIME_W'(t)) + 1 < target)
                t[62] = 1'b1;
        end
        else
        begin
            if (kind < 20 && plan_next != '0)
                target = target - 1;
            else if (kind < 28)
                target = target + $urandom_range(80, 40);
            else if (kind >= 45)
                target = target + $urandom_range(32'(warn_limit_reg) + 3, 1);
            if (target != 0 && $urandom_range(1) == 1)
                t = target * per - $urandom_range(32'((per - 1) / 2), 1);
            else
                t = target * per + $urandom_range(32'(per / 2), 0);
        end
        push_frame(frp_pkg::TIME_W'(t), frp_pkg::HANDLE_W'($urandom()));
    endfunction

    task automatic drain();
        while (frames_pending.size() != 0 || frame_in.valid || slots_awaited.size() != 0)
            @(negedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_reg(frp_pkg::cfg_reg_t idx, logic [frp_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == frp_pkg::REG_OUTPUT_RATE)
            rate_reg = val[frp_pkg::RATE_W-1:0];
        else
            warn_limit_reg = val[frp_pkg::LIMIT_W-1:0];
    endtask

    task automatic random_phase(logic [frp_pkg::RATE_W-1:0] rate,
                                logic [frp_pkg::LIMIT_W-1:0] limit, int count);
        drain();
        write_reg(frp_pkg::REG_OUTPUT_RATE, frp_pkg::CFG_W'(rate));
        write_reg(frp_pkg::REG_SKIP_WARN_LIMIT, {4'($urandom()), limit});
        repeat (count) random_frame();
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            frame_in.valid <= 1'b0;
        end
        else
        begin
            if (frame_in.valid && frame_in.ready)
                pace_frame(frame_in.capture_time_ns, frame_in.frame_handle);
            if (!frame_in.valid || frame_in.ready)
            begin
                if (frames_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_frame = frames_pending.pop_front();
                    frame_in.valid <= 1'b1;
                    frame_in.capture_time_ns <= next_frame.capture;
                    frame_in.frame_handle <= next_frame.handle;
                end
                else
                begin
                    frame_in.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_out.ready <= 1'b0;
        end
        else
        begin
            if (result_out.valid && result_out.ready)
            begin
                seen_slot = make_slot(result_out.out_handle, 64'(result_out.slot_number),
                                      result_out.is_repeat, result_out.skip_warning,
                                      result_out.order_error, result_out.last_of_run);
                if (slots_awaited.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected: handle %h slot %0d rep %b warn %b err %b last %b",
                                 seen_slot.handle, seen_slot.slot, seen_slot.repeat_fill,
                                 seen_slot.warn, seen_slot.order_err, seen_slot.last);
                end
                else
                begin
                    want_slot = slots_awaited.pop_front();
                    if (seen_slot !== want_slot)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("expected: handle %h slot %0d rep %b warn %b err %b last %b",
                                     want_slot.handle, want_slot.slot, want_slot.repeat_fill,
                                     want_slot.warn, want_slot.order_err, want_slot.last);
                            $display("actual:   handle %h slot %0d rep %b warn %b err %b last %b",
                                     seen_slot.handle, seen_slot.slot, seen_slot.repeat_fill,
                                     seen_slot.warn, seen_slot.order_err, seen_slot.last);
                        end
                    end
                end
            end
            result_out.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        #(50_000_000);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        logic [63:0] per;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = frp_pkg::REG_OUTPUT_RATE;
        cfg_data = '0;
        frame_in.valid = 1'b0;
        frame_in.capture_time_ns = '0;
        frame_in.frame_handle = '0;
        result_out.ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: rounding, repeat fill, drop, warning threshold
        per = slot_period_ns();
        push_frame(frp_pkg::TIME_W'(0), 16'h0000);
        push_frame(frp_pkg::TIME_W'(per + per / 2), 16'hFFFF);
        push_frame(frp_pkg::TIME_W'(2 * per + per / 2 + 1), 16'h0001);
        push_frame(frp_pkg::TIME_W'(3 * per), 16'h8000);
        frame_at(7, 16'h1234);
        frame_at(10, 16'h4321);
        drain();
        write_reg(frp_pkg::REG_OUTPUT_RATE, frp_pkg::CFG_W'(1000));
        write_reg(frp_pkg::REG_SKIP_WARN_LIMIT, frp_pkg::CFG_W'(0));
        per = slot_period_ns();
        push_frame(frp_pkg::TIME_W'(11 * per + per / 2), 16'h00FF);
        frame_at(13, 16'hFF00);
        frame_at(113, 16'h0F0F);
        drain();
        write_reg(frp_pkg::REG_SKIP_WARN_LIMIT, frp_pkg::CFG_W'(63));
        frame_at(177, 16'hF0F0);
        frame_at(242, 16'h7FFF);
        push_frame(63'h7FFF_FFFF_FFFF_FFFF, 16'hA5A5);
        frame_at(64'hFFFF_FFFF, 16'h5A5A);
        frame_at(64'h1_0000_0000, 16'hC3C3);
        frame_at(1, 16'h3C3C);

        random_phase(frp_pkg::RATE_W'(1000), frp_pkg::LIMIT_W'(63), 50);
        random_phase(frp_pkg::RATE_W'(1), frp_pkg::LIMIT_W'(0), 50);
        drain();
        send_idle_pct = 74;
        recv_idle_pct = 16;
        random_phase(frp_pkg::RATE_W'(0), frp_pkg::LIMIT_W'($urandom()), 50);
        random_phase(frp_pkg::RATE_W'($urandom_range(1000, 1)),
                     frp_pkg::LIMIT_W'($urandom()), 50);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(frp_pkg::RATE_W'(30), frp_pkg::LIMIT_W'(2), 50);
        random_phase(frp_pkg::RATE_W'($urandom_range(1000, 1)),
                     frp_pkg::LIMIT_W'($urandom()), 50);
        random_phase(frp_pkg::RATE_W'($urandom_range(1000, 1)), frp_pkg::LIMIT_W'(5), 50);

        // stale frame halts the pacer; later frames give nothing
        drain();
        if (plan_next < 2)
            frame_at(5, 16'h0F0F);
        frame_at(64'(plan_next) - 2, 16'hBEEF);
        frame_at(64'(plan_next) + 3, 16'hF00D);
        random_frame();
        drain();
        write_reg(frp_pkg::REG_OUTPUT_RATE, frp_pkg::CFG_W'(500));
        frame_at(64'(plan_next) + 1, 16'h1111);
        drain();

        if (mismatches == 0 && slots_awaited.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
